// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the acknowledgement delay queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold on every checked clock edge.
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, cond) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("assertion failed: invariant");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, cond)
`define ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons)
`endif
`endif

// ===== rtl/madq_pkg.sv =====
// Package with the types and constants of the acknowledgement delay queue.
`default_nettype none
package madq_pkg;

  localparam int AddrW             = 32;
  localparam int DelayW            = 8;
  localparam int CmdW              = 2;
  localparam int DefaultQueueDepth = 16;
  // Most words that one tick may release.
  localparam int MaxRelease        = 16;

  localparam logic [CmdW-1:0] CmdTick  = 2'd0;
  localparam logic [CmdW-1:0] CmdRead  = 2'd1;
  localparam logic [CmdW-1:0] CmdWrite = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CHK  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/memory_ack_delay_queue.sv =====
// Top level of the acknowledgement delay queue: FIFO, countdown cells and drain sequencer.
//
//  channel   direction  handshake               payload
//  command   in         start / busy            cmd, addr
//  config    in         cfg_valid / cfg_ready   cfg_data (bus delay)
//  result    out        valid strobe            ack_addr, ack_is_write, last, overflow
//
// A read or write completion is taken while busy stays low, so another
// command can follow in the next cycle. A tick decrements every nonzero countdown cell
// in the cycle it is accepted; busy then stays high through the head check state, which
// also does the first memory read, and then the emit state releases one word per cycle, as the
// single read port of the address memory delivers one entry each cycle.
// Reset is synchronous and active high; it empties the queue, clears the overflow
// flag and sets the bus delay to zero. The receiver cannot stall: each word is
// shown for exactly one cycle with valid high.
`default_nettype none
`include "assert_macros.svh"
module memory_ack_delay_queue #(
  parameter int QUEUE_DEPTH = madq_pkg::DefaultQueueDepth
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [madq_pkg::CmdW-1:0]     cmd,
  input  wire logic [madq_pkg::AddrW-1:0]    addr,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [madq_pkg::DelayW-1:0]   cfg_data,
  output      logic                          valid,
  output      logic [madq_pkg::AddrW-1:0]    ack_addr,
  output      logic                          ack_is_write,
  output      logic                          last,
  output      logic                          overflow
);

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam int RelW = $clog2(madq_pkg::MaxRelease + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

  madq_pkg::state_t state, state_next;

  logic [IdxW-1:0]                head, tail;
  logic [OccW-1:0]                occ;
  logic [RelW-1:0]                released;
  logic                           overflow_seen;
  logic [madq_pkg::DelayW-1:0]    bus_delay;

  // Address and write flag storage, written at the tail and read at the head.
  logic [madq_pkg::AddrW-1:0]     mem_addr [QUEUE_DEPTH];
  logic                           mem_write [QUEUE_DEPTH];
  logic [madq_pkg::AddrW-1:0]     rd_addr;
  logic                           rd_write;

  // One countdown cell per entry; each nonzero cell decrements itself on a tick.
  logic [madq_pkg::DelayW-1:0]    countdown [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         ready;

  logic cmd_accept, tick_accept, enq_req, enq_ok, pop;

  assign busy       = (state != madq_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign cmd_accept = start && !busy;
  assign tick_accept = cmd_accept && (cmd == madq_pkg::CmdTick);
  assign enq_req    = cmd_accept && ((cmd == madq_pkg::CmdRead) || (cmd == madq_pkg::CmdWrite));
  assign enq_ok     = enq_req && (occ != FullOcc);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ready[i] = (countdown[i] == '0);
    end
  end

  // The head may be released when it is occupied, its countdown has run out and
  // this tick has not yet reached its release limit.
  logic can_pop;
  assign can_pop = (occ != '0) && ready[head] &&
                   (released < RelW'(madq_pkg::MaxRelease));
  assign pop = ((state == madq_pkg::S_CHK) || (state == madq_pkg::S_EMIT)) && can_pop;

  always_comb begin
    state_next = state;
    unique case (state)
      madq_pkg::S_IDLE: begin
        if (tick_accept) state_next = madq_pkg::S_CHK;
      end
      madq_pkg::S_CHK: begin
        state_next = can_pop ? madq_pkg::S_EMIT : madq_pkg::S_IDLE;
      end
      madq_pkg::S_EMIT: begin
        state_next = can_pop ? madq_pkg::S_EMIT : madq_pkg::S_IDLE;
      end
      default: state_next = madq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= madq_pkg::S_IDLE;
      head          <= '0;
      tail          <= '0;
      occ           <= '0;
      released      <= '0;
      overflow_seen <= 1'b0;
      bus_delay     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) bus_delay <= cfg_data;
      if (enq_req && !enq_ok) overflow_seen <= 1'b1;
      if (enq_ok) begin
        tail <= (tail == LastIdx) ? '0 : tail + 1'b1;
        occ  <= occ + 1'b1;
      end
      if (tick_accept) released <= '0;
      if (pop) begin
        head     <= (head == LastIdx) ? '0 : head + 1'b1;
        occ      <= occ - 1'b1;
        released <= released + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq_ok) begin
      mem_addr[tail]  <= addr;
      mem_write[tail] <= (cmd == madq_pkg::CmdWrite);
    end
    if (pop) begin
      rd_addr  <= mem_addr[head];
      rd_write <= mem_write[head];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (enq_ok && (tail == IdxW'(i))) begin
        countdown[i] <= bus_delay;
      end else if (tick_accept && (countdown[i] != '0)) begin
        countdown[i] <= countdown[i] - 1'b1;
      end
    end
  end

  // A word is shown in every emit cycle; it is the last one when no further
  // head can be released behind it.
  assign valid        = (state == madq_pkg::S_EMIT);
  assign ack_addr     = rd_addr;
  assign ack_is_write = rd_write;
  assign last         = valid && !can_pop;
  assign overflow     = overflow_seen;

  `ASSERT_ALWAYS(a_occ_bound, clk, rst, occ <= FullOcc)
  `ASSERT_NEXT(a_drain_continues, clk, rst, valid && !last, valid)
  `ASSERT_NEXT(a_tick_busy, clk, rst, tick_accept, busy && !valid)
  `ASSERT_IMPLY(a_no_pop_when_empty, clk, rst, pop, occ != '0)

endmodule
`default_nettype wire
